/* rtl/tap_tempo_estimator_core_defines.svh */
// Assertion macros shared by the tap tempo estimator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TAP_TEMPO_ESTIMATOR_CORE_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_CORE_DEFINES_SVH

// same-cycle implication
`define TTE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tte_pkg.sv */
// Shared types and constants of the tap tempo estimator.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

   localparam int TAP_COUNT   = 4;
   localparam int SLOT_W      = $clog2(TAP_COUNT);
   localparam int CNT_W       = $clog2(TAP_COUNT + 1);
   localparam int DATA_W      = 32;
   localparam int SUM_W       = DATA_W + $clog2(TAP_COUNT);
   localparam int LEVEL_W     = 16;
   localparam int Q_W         = LEVEL_W + 1;
   localparam int THREE_W     = DATA_W + 2;
   localparam int STEP_W      = $clog2(SUM_W);
   localparam int CSR_IDX_W   = 2;

   localparam int MEAN_STEPS  = SUM_W;
   localparam int MOD_STEPS   = DATA_W;
   localparam int LEVEL_STEPS = LEVEL_W;

   localparam logic [DATA_W-1:0] RESET_GAP_INIT      = 32'd96000;
   localparam logic [DATA_W-1:0] DEFAULT_PERIOD_INIT = 32'd24000;
   localparam logic [DATA_W-1:0] BEAT_WINDOW_INIT    = 32'd4800;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESET_GAP      = 2'd0,
      CSR_DEFAULT_PERIOD = 2'd1,
      CSR_BEAT_WINDOW    = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_TAP   = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      DIV_NONE,
      DIV_MEAN,
      DIV_MOD,
      DIV_LEVEL
   } div_load_type;

   typedef struct packed {
      logic         capture;
      logic         ring_update;
      logic         scan_step;
      div_load_type div_load;
      logic         div_step;
      logic         set_period;
      logic         level_prep;
      logic         square;
      logic         load_result;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tap;
      logic count_zero;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/tte_if.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on tte_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tte_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [tte_pkg::DATA_W-1:0]  now;

   modport source (output valid, func, now, input ready);
   modport sink   (input valid, func, now, output ready);
endinterface

interface tte_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tte_pkg::DATA_W-1:0]  period;
   logic                        beat_flag;
   logic [tte_pkg::LEVEL_W-1:0] beat_level;

   modport source (output valid, period, beat_flag, beat_level, input ready);
   modport sink   (input valid, period, beat_flag, beat_level, output ready);
endinterface

`default_nettype wire

/* rtl/tte_datapath.sv */
// Datapath: config registers, tap ring, gap accumulator, shared restoring
// divider, squarer and response register. Depends on tte_pkg and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "tap_tempo_estimator_core_defines.svh"

module tte_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  tte_pkg::dp_cmd_type               cmd,
   output tte_pkg::dp_status_type            status,
   input  wire                               req_func,
   input  wire  [tte_pkg::DATA_W-1:0]        req_now,
   input  wire                               csr_we,
   input  wire  [tte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [tte_pkg::DATA_W-1:0]        csr_wdata,
   output logic [tte_pkg::DATA_W-1:0]        rsp_period,
   output logic                              rsp_beat_flag,
   output logic [tte_pkg::LEVEL_W-1:0]       rsp_beat_level
);

   localparam int DW = tte_pkg::DATA_W;
   localparam int SW = tte_pkg::SUM_W;
   localparam int TW = tte_pkg::THREE_W;
   localparam int QW = tte_pkg::Q_W;
   localparam int LW = tte_pkg::LEVEL_W;
   localparam int NT = tte_pkg::TAP_COUNT;

   // config
   logic [DW-1:0] reset_gap_ff, reset_gap_in;
   logic [DW-1:0] default_period_ff, default_period_in;
   logic [DW-1:0] beat_window_ff, beat_window_in;

   // tempo state
   logic [DW-1:0]                ring_ff [NT];
   logic [DW-1:0]                ring_in [NT];
   logic [tte_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [DW-1:0]                last_tap_ff, last_tap_in;
   logic [DW-1:0]                period_ff, period_in;

   // per-item working registers
   logic                         func_ff, func_in;
   logic [DW-1:0]                now_ff, now_in;
   logic [SW-1:0]                sum_ff, sum_in;
   logic [tte_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [DW-1:0]                rem_ff, rem_in;
   logic [SW-1:0]                num_ff, num_in;
   logic [SW-1:0]                quo_ff, quo_in;
   logic [DW-1:0]                den_ff, den_in;
   logic [TW-1:0]                three_ff, three_in;
   logic                         flag_ff, flag_in;
   logic                         over_ff, over_in;
   logic [2*QW-1:0]              sq_ff, sq_in;
   logic [DW-1:0]                rsp_period_ff, rsp_period_in;
   logic                         rsp_flag_ff, rsp_flag_in;
   logic [LW-1:0]                rsp_level_ff, rsp_level_in;

   logic                         stale;
   logic [tte_pkg::SLOT_W-1:0]   wr_slot;
   logic [DW-1:0]                scan_cur;
   logic [DW-1:0]                scan_nxt;
   logic [DW:0]                  rem_sh;
   logic                         div_ge;
   logic [DW:0]                  div_diff;
   logic                         level_hi;
   logic [DW-1:0]                eff_default;
   logic [DW-1:0]                mean;
   logic [QW:0]                  sq_hi;
   logic [QW-1:0]                lvl_full;

   always_comb begin
      reset_gap_in      = reset_gap_ff;
      default_period_in = default_period_ff;
      beat_window_in    = beat_window_ff;
      if (csr_we) begin
         case (csr_index)
            tte_pkg::CSR_RESET_GAP:      reset_gap_in      = csr_wdata;
            tte_pkg::CSR_DEFAULT_PERIOD: default_period_in = csr_wdata;
            tte_pkg::CSR_BEAT_WINDOW:    beat_window_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   assign func_in = cmd.capture ? req_func : func_ff;
   assign now_in  = cmd.capture ? req_now  : now_ff;

   // ring write and gap scan; the scan rotates the ring through taps 0 and 1
   assign stale    = (now_ff - last_tap_ff) > reset_gap_ff;
   assign wr_slot  = stale ? '0 : slot_ff;
   assign scan_cur = ring_ff[0];
   assign scan_nxt = ring_ff[1];

   always_comb begin
      ring_in     = ring_ff;
      slot_in     = slot_ff;
      last_tap_in = last_tap_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      if (cmd.ring_update) begin
         sum_in   = '0;
         count_in = '0;
         if (func_ff == tte_pkg::FUNC_TAP) begin
            for (int j = 0; j < NT; j++) begin
               if (wr_slot == tte_pkg::SLOT_W'(j)) begin
                  ring_in[j] = now_ff;
               end else if (stale) begin
                  ring_in[j] = '0;
               end
            end
            slot_in     = (wr_slot == tte_pkg::SLOT_W'(NT - 1)) ? '0 : wr_slot + 1'b1;
            last_tap_in = now_ff;
         end
      end else if (cmd.scan_step) begin
         for (int j = 0; j < NT; j++) begin
            ring_in[j] = ring_ff[(j + 1) % NT];
         end
         if (scan_cur != '0 && scan_nxt > scan_cur) begin
            sum_in   = sum_ff + SW'(scan_nxt - scan_cur);
            count_in = count_ff + 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit per step
   assign rem_sh   = {rem_ff, num_ff[SW-1]};
   assign div_ge   = rem_sh >= {1'b0, den_ff};
   assign div_diff = rem_sh - {1'b0, den_ff};
   assign level_hi = three_ff == {2'b00, period_ff};

   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      case (cmd.div_load)
         tte_pkg::DIV_MEAN: begin
            rem_in = '0;
            num_in = sum_ff;
            quo_in = '0;
            den_in = DW'(count_ff);
         end
         tte_pkg::DIV_MOD: begin
            rem_in = '0;
            num_in = {now_ff, {(SW - DW){1'b0}}};
            quo_in = '0;
            den_in = period_ff;
         end
         tte_pkg::DIV_LEVEL: begin
            rem_in = level_hi ? '0 : three_ff[DW-1:0];
            num_in = '0;
            quo_in = SW'(level_hi);
            den_in = period_ff;
         end
         default: begin
            if (cmd.div_step) begin
               rem_in = div_ge ? div_diff[DW-1:0] : rem_sh[DW-1:0];
               num_in = {num_ff[SW-2:0], 1'b0};
               quo_in = {quo_ff[SW-2:0], div_ge};
            end
         end
      endcase
   end

   assign eff_default = (default_period_ff == '0) ? DW'(1) : default_period_ff;
   assign mean        = quo_ff[DW-1:0];
   assign period_in   = !cmd.set_period ? period_ff :
                        (count_ff == '0 || mean == '0) ? eff_default : mean;

   assign three_in = cmd.level_prep ? ({2'b00, rem_ff} + {1'b0, rem_ff, 1'b0}) : three_ff;
   assign flag_in  = cmd.level_prep ? (rem_ff < beat_window_ff) : flag_ff;
   assign over_in  = (cmd.div_load == tte_pkg::DIV_LEVEL) ?
                     (three_ff > {2'b00, period_ff}) : over_ff;
   assign sq_in    = cmd.square ? quo_ff[QW-1:0] * quo_ff[QW-1:0] : sq_ff;

   // level = 1 - q^2 in Q0.16, saturated
   assign sq_hi    = sq_ff[2*QW-1:LW];
   assign lvl_full = {1'b1, {LW{1'b0}}} - sq_hi[QW-1:0];

   always_comb begin
      rsp_period_in = rsp_period_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_level_in  = rsp_level_ff;
      if (cmd.load_result) begin
         rsp_period_in = period_ff;
         rsp_flag_in   = flag_ff;
         if (over_ff) begin
            rsp_level_in = '0;
         end else if (sq_hi == '0) begin
            rsp_level_in = '1;
         end else begin
            rsp_level_in = lvl_full[LW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_gap_ff      <= tte_pkg::RESET_GAP_INIT;
         default_period_ff <= tte_pkg::DEFAULT_PERIOD_INIT;
         beat_window_ff    <= tte_pkg::BEAT_WINDOW_INIT;
         for (int j = 0; j < NT; j++) begin
            ring_ff[j] <= '0;
         end
         slot_ff           <= '0;
         last_tap_ff       <= '0;
         period_ff         <= tte_pkg::DEFAULT_PERIOD_INIT;
      end else begin
         reset_gap_ff      <= reset_gap_in;
         default_period_ff <= default_period_in;
         beat_window_ff    <= beat_window_in;
         ring_ff           <= ring_in;
         slot_ff           <= slot_in;
         last_tap_ff       <= last_tap_in;
         period_ff         <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      now_ff        <= now_in;
      sum_ff        <= sum_in;
      count_ff      <= count_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      den_ff        <= den_in;
      three_ff      <= three_in;
      flag_ff       <= flag_in;
      over_ff       <= over_in;
      sq_ff         <= sq_in;
      rsp_period_ff <= rsp_period_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign status.is_tap     = func_ff == tte_pkg::FUNC_TAP;
   assign status.count_zero = count_ff == '0;

   assign rsp_period     = rsp_period_ff;
   assign rsp_beat_flag  = rsp_flag_ff;
   assign rsp_beat_level = rsp_level_ff;

   `TTE_ASSERT_NOW(a_period_nonzero, clock, reset, 1'b1, period_ff != '0, "period reached zero")
   `TTE_ASSERT_NOW(a_slot_range, clock, reset, 1'b1, slot_ff <= tte_pkg::SLOT_W'(NT - 1), "write slot out of range")
   `TTE_ASSERT_NEXT(a_level_gated, clock, reset, cmd.load_result && over_ff, rsp_level_ff == '0, "level nonzero past a third")

endmodule

`default_nettype wire

/* rtl/tte_ctrl.sv */
// Controller: sequences ring update, gap scan, divisions and response load.
// Depends on tte_pkg and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "tap_tempo_estimator_core_defines.svh"

module tte_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output tte_pkg::dp_cmd_type           cmd,
   input  tte_pkg::dp_status_type        status
);

   localparam int SW = tte_pkg::STEP_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RING,
      ST_SCAN,
      ST_MEAN_LOAD,
      ST_MEAN_DIV,
      ST_PERIOD,
      ST_MOD_LOAD,
      ST_MOD_DIV,
      ST_LEVEL_PREP,
      ST_LEVEL_LOAD,
      ST_LEVEL_DIV,
      ST_SQUARE,
      ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_RING;
            end
         end
         ST_RING: begin
            cmd.ring_update = 1'b1;
            state_in        = status.is_tap ? ST_SCAN : ST_MOD_LOAD;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (cnt_ff == SW'(tte_pkg::TAP_COUNT - 1)) begin
               state_in = ST_MEAN_LOAD;
            end
         end
         ST_MEAN_LOAD: begin
            cmd.div_load = tte_pkg::DIV_MEAN;
            state_in     = status.count_zero ? ST_PERIOD : ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == SW'(tte_pkg::MEAN_STEPS - 1)) begin
               state_in = ST_PERIOD;
            end
         end
         ST_PERIOD: begin
            cmd.set_period = 1'b1;
            state_in       = ST_MOD_LOAD;
         end
         ST_MOD_LOAD: begin
            cmd.div_load = tte_pkg::DIV_MOD;
            state_in     = ST_MOD_DIV;
         end
         ST_MOD_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == SW'(tte_pkg::MOD_STEPS - 1)) begin
               state_in = ST_LEVEL_PREP;
            end
         end
         ST_LEVEL_PREP: begin
            cmd.level_prep = 1'b1;
            state_in       = ST_LEVEL_LOAD;
         end
         ST_LEVEL_LOAD: begin
            cmd.div_load = tte_pkg::DIV_LEVEL;
            state_in     = ST_LEVEL_DIV;
         end
         ST_LEVEL_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == SW'(tte_pkg::LEVEL_STEPS - 1)) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TTE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready high after accept")
   `TTE_ASSERT_NOW(a_load_when_free, clock, reset, cmd.load_result, out_free, "response overwritten")
   `TTE_ASSERT_NEXT(a_result_follows, clock, reset, cmd.load_result, rsp_valid_ff && req_ready, "result not posted")

endmodule

`default_nettype wire

/* rtl/tap_tempo_estimator_core.sv */
// Tap tempo estimator, top level: joins controller, datapath and channels.
// Depends on tte_pkg, tte_if, tte_ctrl and tte_datapath.
//
// Usage:
//   req_bus carries one beat per item: func (0 tap, 1 query) and now, the
//   running sample time. rsp_bus returns one beat per item: period,
//   beat_flag and beat_level (unsigned Q0.16).
//   csr_we/csr_index/csr_wdata write reset_gap (0), default_period (1) and
//   beat_window (2); other indexes are ignored. Write only while idle.
//   Items are handled one at a time. A query goes from ring update straight
//   to the phase modulo; a tap first scans the ring and divides for the mean
//   gap, skipping that division when the ring holds no positive gap. A new
//   item can be accepted in the cycle after its predecessor's result is registered.
//   The shared restoring divider gives one quotient bit per cycle: mean gap
//   (SUM_W steps), phase modulo (32) and level ratio (16).
//   A result waiting in the response register does not block the next
//   item; only the following result stalls until rsp ready.
//   Reset is synchronous: tap ring, write slot and last tap time clear,
//   the period and config registers return to their defaults, both channels idle.
`timescale 1ns / 1ps
`default_nettype none

module tap_tempo_estimator_core (
   input  wire                            clock,
   input  wire                            reset,
   tte_req_if.sink                        req_bus,
   tte_rsp_if.source                      rsp_bus,
   input  wire                            csr_we,
   input  wire  [tte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [tte_pkg::DATA_W-1:0]     csr_wdata
);

   tte_pkg::dp_cmd_type    cmd;
   tte_pkg::dp_status_type status;

   tte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tte_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_bus.func),
      .req_now        (req_bus.now),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_period     (rsp_bus.period),
      .rsp_beat_flag  (rsp_bus.beat_flag),
      .rsp_beat_level (rsp_bus.beat_level)
   );

endmodule

`default_nettype wire

/* test/tap_tempo_check.sv */
// Scoreboard for the tap tempo estimator: tracks CSR writes and request beats,
// predicts period, beat flag and beat level, and checks every response beat.
// Depends on tte_pkg and the channel interfaces in tte_if.
`timescale 1ns / 1ps

module tap_tempo_check
   import tte_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   tte_req_if                    req,
   tte_rsp_if                    rsp,
   input  wire                   csr_we,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [DATA_W-1:0]      csr_wdata,
   output int unsigned           results_seen,
   output int unsigned           mismatches
);

   typedef struct packed {
      logic [DATA_W-1:0]  period;
      logic               beat_flag;
      logic [LEVEL_W-1:0] beat_level;
   } beat_state_type;

   logic [DATA_W-1:0] gap_limit;
   logic [DATA_W-1:0] fallback_period;
   logic [DATA_W-1:0] window_len;
   logic [DATA_W-1:0] tap_ring [TAP_COUNT];
   int unsigned       ring_slot;
   logic [DATA_W-1:0] last_tap;
   logic [DATA_W-1:0] tempo;

   beat_state_type    expected_beats [$];
   int unsigned       seen_count;
   int unsigned       bad_count;

   function automatic logic [DATA_W-1:0] safe_default();
      return (fallback_period == '0) ? DATA_W'(1) : fallback_period;
   endfunction

   // mean of positive gaps between ring neighbors, wrapping, empty entries skipped
   function automatic logic [DATA_W-1:0] estimate_period();
      logic [63:0]       gap_sum;
      int unsigned       gap_count;
      logic [DATA_W-1:0] cur;
      logic [DATA_W-1:0] nxt;
      gap_sum = '0;
      gap_count = 0;
      for (int i = 0; i < TAP_COUNT; i++) begin
         cur = tap_ring[i];
         nxt = tap_ring[(i + 1) % TAP_COUNT];
         if (cur != '0 && nxt > cur) begin
            gap_sum += 64'(nxt - cur);
            gap_count++;
         end
      end
      if (gap_count == 0)
         return safe_default();
      gap_sum = gap_sum / 64'(gap_count);
      if (gap_sum == '0)
         return safe_default();
      return gap_sum[DATA_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] envelope_level(input logic [DATA_W-1:0] ph,
                                                          input logic [DATA_W-1:0] per);
      logic [63:0] three_ph;
      logic [63:0] ratio;
      logic [63:0] square;
      logic [63:0] level;
      three_ph = 64'(ph) * 64'd3;
      if (three_ph > 64'(per))
         return '0;
      ratio = (three_ph << 16) / 64'(per);
      square = (ratio * ratio) >> 16;
      level = 64'd65536 - square;
      if (level > 64'd65535)
         level = 64'd65535;
      return level[LEVEL_W-1:0];
   endfunction

   function automatic beat_state_type predict_beat_state(input func_type op,
                                                         input logic [DATA_W-1:0] stamp);
      beat_state_type    result;
      logic [DATA_W-1:0] elapsed;
      logic [DATA_W-1:0] ph;
      if (op == FUNC_TAP) begin
         elapsed = stamp - last_tap;
         if (elapsed > gap_limit) begin
            for (int i = 0; i < TAP_COUNT; i++)
               tap_ring[i] = '0;
            ring_slot = 0;
         end
         last_tap = stamp;
         tap_ring[ring_slot] = stamp;
         ring_slot = (ring_slot + 1) % TAP_COUNT;
         tempo = estimate_period();
      end
      if (tempo == '0)
         tempo = DATA_W'(1);
      ph = stamp % tempo;
      result.period = tempo;
      result.beat_flag = (ph < window_len);
      result.beat_level = envelope_level(ph, tempo);
      return result;
   endfunction

   always @(posedge clock) begin
      beat_state_type got;
      beat_state_type want;
      if (reset) begin
         gap_limit = RESET_GAP_INIT;
         fallback_period = DEFAULT_PERIOD_INIT;
         window_len = BEAT_WINDOW_INIT;
         for (int i = 0; i < TAP_COUNT; i++)
            tap_ring[i] = '0;
         ring_slot = 0;
         last_tap = '0;
         tempo = DEFAULT_PERIOD_INIT;
         expected_beats.delete();
         seen_count = 0;
         bad_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RESET_GAP:      gap_limit = csr_wdata;
               CSR_DEFAULT_PERIOD: fallback_period = csr_wdata;
               CSR_BEAT_WINDOW:    window_len = csr_wdata;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got.period = rsp.period;
            got.beat_flag = rsp.beat_flag;
            got.beat_level = rsp.beat_level;
            if (expected_beats.size() == 0) begin
               if (bad_count < 10)
                  $display("%0t: unexpected rsp beat period=%0d flag=%0b level=%0d",
                           $realtime, got.period, got.beat_flag, got.beat_level);
               bad_count++;
            end else begin
               want = expected_beats.pop_front();
               seen_count++;
               if (got.period !== want.period || got.beat_flag !== want.beat_flag ||
                   got.beat_level !== want.beat_level) begin
                  if (bad_count < 10)
                     $display({"%0t: rsp beat %0d mismatch: period exp %0d got %0d, ",
                               "flag exp %0b got %0b, level exp %0d got %0d"},
                              $realtime, seen_count, want.period, got.period,
                              want.beat_flag, got.beat_flag, want.beat_level, got.beat_level);
                  bad_count++;
               end
            end
         end
         if (req.valid && req.ready)
            expected_beats.push_back(predict_beat_state(func_type'(req.func), req.now));
      end
      results_seen <= seen_count;
      mismatches <= bad_count;
   end

endmodule

/* test/testbench.sv */
// Top of the tap tempo estimator test: clock, reset, CSR settings, tap/query
// stimulus with bursty sender and stalling receiver, and the verdict.
// Depends on tte_pkg, tte_if, tap_tempo_estimator_core and tap_tempo_check.
`timescale 1ns / 1ps

module testbench;
   import tte_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned PHASE_ITEMS  = 150;
   localparam int unsigned PHASES       = 6;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;
   int unsigned          results_seen;
   int unsigned          mismatches;
   int unsigned          items_sent;
   int unsigned          burst_left;

   tte_req_if req_chan ();
   tte_rsp_if rsp_chan ();

   tap_tempo_estimator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_chan),
      .rsp_bus   (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tap_tempo_check beat_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .results_seen (results_seen),
      .mismatches   (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tap_tempo_estimator_core test failed");
      $finish;
   end

   // receiver: stall pattern cycles through modes, with periodic long hold-offs
   initial begin : receiver
      int unsigned rx_cycles;
      int unsigned hold_left;
      rx_cycles = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (rx_cycles % 40000 == 20000)
            hold_left = 1500;
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case ((rx_cycles / 700) % 4)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_chan.ready <= ($urandom_range(0, 5) == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   task automatic send_item(input func_type op, input logic [DATA_W-1:0] stamp);
      req_chan.valid <= 1'b1;
      req_chan.func <= op;
      req_chan.now <= stamp;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      items_sent++;
      burst_left--;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) @(posedge clock);
         else
            repeat ($urandom_range(4, 120)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 6);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (results_seen != items_sent)
         @(posedge clock);
   endtask

   task automatic run_directed();
      send_item(FUNC_QUERY, 32'd0);
      send_item(FUNC_TAP, 32'd0);
      send_item(FUNC_TAP, 32'd1000);
      send_item(FUNC_TAP, 32'd2000);
      send_item(FUNC_QUERY, '1);
      send_item(FUNC_TAP, '1);
      send_item(FUNC_TAP, 32'd5);       // wraps past the top of the counter
      send_item(FUNC_TAP, 32'd100);
      send_item(FUNC_TAP, 32'd50);      // time runs backwards, history clears
      send_item(FUNC_TAP, 32'd12000);
      send_item(FUNC_TAP, 32'd24000);
      send_item(FUNC_TAP, 32'd36000);
      send_item(FUNC_TAP, 32'd48000);
      send_item(FUNC_TAP, 32'd60000);   // ring overwrite, period 12000
      send_item(FUNC_QUERY, 32'd60000);
      send_item(FUNC_QUERY, 32'd60001);
      send_item(FUNC_QUERY, 32'd63999);
      send_item(FUNC_QUERY, 32'd64000); // exactly a third of the period
      send_item(FUNC_QUERY, 32'd64001);
      send_item(FUNC_QUERY, 32'd64799);
      send_item(FUNC_QUERY, 32'd64800);
      send_item(FUNC_QUERY, 32'hAAAA_5555);
   endtask

   // mostly tap trains at a steady spacing with queries between, plus noise
   task automatic run_random(input int unsigned count);
      int unsigned       done_items;
      int unsigned       taps;
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] spacing;
      done_items = 0;
      stamp = $urandom;
      while (done_items < count) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
               0: send_item(func_type'($urandom_range(0, 1)), $urandom);
               1: send_item(FUNC_TAP, ($urandom_range(0, 1) == 1) ? '1 : '0);
               2: send_item(FUNC_TAP, stamp - $urandom_range(1, 5000));
               default: send_item(FUNC_QUERY, $urandom);
            endcase
            done_items++;
         end else begin
            case ($urandom_range(0, 7))
               0:       spacing = $urandom_range(1, 1 << 20);
               1:       spacing = $urandom_range(1, 32'h7FFF_FFFF);
               default: spacing = $urandom_range(1, 40000);
            endcase
            if ($urandom_range(0, 3) == 0)
               stamp = stamp + $urandom;
            taps = $urandom_range(2, 7);
            for (int k = 0; k < taps; k++) begin
               stamp = stamp + spacing + $urandom_range(0, spacing / 8);
               send_item(FUNC_TAP, stamp);
               done_items++;
               repeat ($urandom_range(0, 2)) begin
                  send_item(FUNC_QUERY, stamp + $urandom_range(0, spacing));
                  done_items++;
               end
            end
         end
      end
   endtask

   initial begin : stimulus
      items_sent = 0;
      burst_left = 4;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_RESET_GAP;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.func <= FUNC_TAP;
      req_chan.now <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int phase = 1; phase <= PHASES; phase++) begin
         wait_idle();
         case (phase)
            1: begin
               write_csr(CSR_UNUSED, $urandom);
               write_csr(CSR_RESET_GAP, RESET_GAP_INIT);
               write_csr(CSR_DEFAULT_PERIOD, DEFAULT_PERIOD_INIT);
               write_csr(CSR_BEAT_WINDOW, BEAT_WINDOW_INIT);
            end
            2: begin
               write_csr(CSR_RESET_GAP, '0);
               write_csr(CSR_DEFAULT_PERIOD, '0);
               write_csr(CSR_BEAT_WINDOW, '0);
            end
            3: begin
               write_csr(CSR_RESET_GAP, '1);
               write_csr(CSR_DEFAULT_PERIOD, '1);
               write_csr(CSR_BEAT_WINDOW, '1);
            end
            4: begin
               write_csr(CSR_RESET_GAP, $urandom_range(1000, 200000));
               write_csr(CSR_DEFAULT_PERIOD, $urandom_range(1, 100000));
               write_csr(CSR_BEAT_WINDOW, $urandom_range(0, 30000));
            end
            5: begin
               write_csr(CSR_RESET_GAP, '1);
               write_csr(CSR_DEFAULT_PERIOD, $urandom_range(1, 100));
               write_csr(CSR_BEAT_WINDOW, $urandom_range(0, 100));
            end
            default: begin
               write_csr(CSR_UNUSED, $urandom);
               write_csr(CSR_RESET_GAP, $urandom);
               write_csr(CSR_DEFAULT_PERIOD, $urandom);
               write_csr(CSR_BEAT_WINDOW, $urandom);
            end
         endcase
         csr_we <= 1'b0;
         run_random(PHASE_ITEMS);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tap_tempo_estimator_core test passed");
      else
         $display("tap_tempo_estimator_core test failed");
      $finish;
   end

endmodule
